// ----- rtl/vba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vba_pkg;

    // Width of the slot and batch count result fields
    localparam int SLOT_W = 4;

    // Primitive codes that change batch handling
    localparam logic [3:0] PRIM_LINE_LOOP  = 4'd2;
    localparam logic [3:0] PRIM_LINE_STRIP = 4'd3;
    localparam logic [3:0] PRIM_TRISTRIP   = 4'd5;
    localparam logic [3:0] PRIM_FAN        = 4'd6;
    localparam logic [3:0] PRIM_QUADS      = 4'd7;
    localparam logic [3:0] PRIM_QUADSTRIP  = 4'd8;
    localparam logic [3:0] PRIM_POLYGON    = 4'd9;

    // Vertices per independent quad
    localparam int QUAD_SIZE = 4;

    // One stored vertex
    typedef struct packed {
        logic [63:0] pos_xy;
        logic [31:0] pos_z;
        logic [63:0] tex;
        logic [31:0] color;
        logic [63:0] normal_xy;
        logic [31:0] normal_z;
    } vtx_t;

    // Number of trailing vertices carried into the next batch
    function automatic logic [1:0] overhang(input logic [3:0] prim);
        logic [1:0] n;
        begin
            case (prim) inside
                PRIM_LINE_LOOP, PRIM_LINE_STRIP, PRIM_POLYGON: n = 2'd1;
                PRIM_TRISTRIP, PRIM_FAN, PRIM_QUADSTRIP:        n = 2'd2;
                default:                                        n = 2'd0;
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vertex_batch_assembler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Vertex batch assembler. Takes one vertex per request and places it in the next
// slot of a BATCH_DEPTH-entry batch, reporting each write; when the batch fills, or
// a quad completes in quads mode, it reports a flush with the vertex count and then
// the overhang copies that start the next batch (fan and polygon keep slot 0 and
// carry the last vertices after it). Rate: a vertex that yields k results (1 to 5)
// holds the input until its last result is emitted, so ordinary vertices pass at one
// per cycle, the rate at which the result register presents results, while res_ready
// holds. An accepted vertex goes to the sequencer, then its first result to the
// result register. Only slot 0 and the slot before the last are ever read back, so
// only those two are stored; no clearing pass is needed after reset. The slot and
// batch count fields are 4 bits wide and keep the low bits for deeper batches.
module vertex_batch_assembler
    import vba_pkg::*;
#(
    parameter int BATCH_DEPTH = 12
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          cfg_wr_en,
    input  wire logic [3:0]    cfg_wr_data,

    input  wire logic          vtx_valid,
    output logic               vtx_ready,
    input  wire logic [31:0]   pos_x,
    input  wire logic [31:0]   pos_y,
    input  wire logic [31:0]   pos_z,
    input  wire logic [31:0]   tex_u,
    input  wire logic [31:0]   tex_v,
    input  wire logic [31:0]   rgba,
    input  wire logic [31:0]   norm_x,
    input  wire logic [31:0]   norm_y,
    input  wire logic [31:0]   norm_z,

    output logic               res_valid,
    input  wire logic          res_ready,
    output logic               kind,
    output logic [SLOT_W-1:0]  slot,
    output logic [63:0]        pos_xy,
    output logic [31:0]        pos_zw,
    output logic [63:0]        tex_uv,
    output logic [31:0]        color_word,
    output logic [63:0]        normal_xy,
    output logic [31:0]        normal_zz,
    output logic [SLOT_W-1:0]  batch_count,
    output logic               last_result
);

    localparam int CW = $clog2(BATCH_DEPTH + 1);

    // Configuration and batch state
    logic [3:0]     prim_reg, prim_next;
    logic [CW-1:0]  fill_reg, fill_next;
    vtx_t           first_reg, first_next;
    vtx_t           pen_reg, pen_next;

    // Result sequencer holding the accepted vertex
    logic           gen_busy_reg, gen_busy_next;
    logic [2:0]     gen_idx_reg, gen_idx_next;
    logic [2:0]     gen_cnt_reg, gen_cnt_next;
    logic [SLOT_W-1:0] gen_slot_reg, gen_slot_next;
    logic [SLOT_W-1:0] gen_bcount_reg, gen_bcount_next;
    logic [1:0]     gen_over_reg, gen_over_next;
    logic           gen_fan_reg, gen_fan_next;
    vtx_t           gen_cur_reg, gen_cur_next;
    vtx_t           gen_pen_reg, gen_pen_next;
    vtx_t           gen_first_reg, gen_first_next;

    // Result register
    logic           res_valid_reg, res_valid_next;
    logic           res_kind_reg, res_kind_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    vtx_t           res_vtx_reg, res_vtx_next;
    logic [SLOT_W-1:0] res_bcount_reg, res_bcount_next;
    logic           res_last_reg, res_last_next;

    // Handshake and per-vertex decode
    logic           accept;
    logic           out_free;
    logic           emit;
    logic           gen_last;
    vtx_t           cur;
    logic [CW-1:0]  slot_sel;
    logic [CW-1:0]  fill_inc;
    logic           fanlike;
    logic [1:0]     over;
    logic           flush;

    // Result selection
    logic [2:0]     tail_pos;
    logic [2:0]     tail_idx;
    logic           sel_kind;
    logic [SLOT_W-1:0] sel_slot;
    vtx_t           sel_vtx;
    logic [SLOT_W-1:0] sel_bcount;

    // Handshake
    assign out_free  = !res_valid_reg || res_ready;
    assign gen_last  = (gen_idx_reg == (gen_cnt_reg - 3'd1));
    assign emit      = gen_busy_reg && out_free;
    assign vtx_ready = !gen_busy_reg || (emit && gen_last);
    assign accept    = vtx_valid && vtx_ready;

    // Pack the incoming vertex
    always_comb
    begin
        cur.pos_xy    = {pos_y, pos_x};
        cur.pos_z     = pos_z;
        cur.tex       = {tex_v, tex_u};
        cur.color     = rgba;
        cur.normal_xy = {norm_y, norm_x};
        cur.normal_z  = norm_z;
    end

    // Decide slot, flush and overhang for the incoming vertex
    always_comb
    begin
        slot_sel = (fill_reg >= CW'(BATCH_DEPTH)) ? '0 : fill_reg;
        fill_inc = slot_sel + CW'(1);
        fanlike  = (prim_reg == PRIM_FAN) || (prim_reg == PRIM_POLYGON);
        over     = overhang(prim_reg);
        flush    = (fill_inc == CW'(BATCH_DEPTH))
                || ((prim_reg == PRIM_QUADS) && (fill_inc == CW'(QUAD_SIZE)));
    end

    // Update configuration and batch state
    always_comb
    begin
        prim_next  = cfg_wr_en ? cfg_wr_data : prim_reg;
        fill_next  = fill_reg;
        first_next = first_reg;
        pen_next   = pen_reg;
        if (accept)
        begin
            if (flush)
                fill_next = CW'(over) + CW'(fanlike);
            else
                fill_next = fill_inc;
            if (slot_sel == '0)
                first_next = cur;
            else if (flush && !fanlike && (over != 2'd0))
                first_next = (over == 2'd2) ? pen_reg : cur;
            if (slot_sel == CW'(BATCH_DEPTH - 2))
                pen_next = cur;
        end
    end

    // Load the sequencer on accept, advance it on each emitted result
    always_comb
    begin
        gen_busy_next   = gen_busy_reg;
        gen_idx_next    = gen_idx_reg;
        gen_cnt_next    = gen_cnt_reg;
        gen_slot_next   = gen_slot_reg;
        gen_bcount_next = gen_bcount_reg;
        gen_over_next   = gen_over_reg;
        gen_fan_next    = gen_fan_reg;
        gen_cur_next    = gen_cur_reg;
        gen_pen_next    = gen_pen_reg;
        gen_first_next  = gen_first_reg;
        if (emit)
        begin
            gen_idx_next = gen_idx_reg + 3'd1;
            if (gen_last)
                gen_busy_next = 1'b0;
        end
        if (accept)
        begin
            gen_busy_next   = 1'b1;
            gen_idx_next    = 3'd0;
            gen_cnt_next    = flush ? (3'd2 + 3'(over) + 3'(fanlike)) : 3'd1;
            gen_slot_next   = SLOT_W'(slot_sel);
            gen_bcount_next = SLOT_W'(fill_inc);
            gen_over_next   = over;
            gen_fan_next    = fanlike;
            gen_cur_next    = cur;
            gen_pen_next    = pen_reg;
            gen_first_next  = first_reg;
        end
    end

    // Select the result at the current sequence position
    always_comb
    begin
        tail_pos   = gen_idx_reg - 3'd2;
        tail_idx   = gen_fan_reg ? (tail_pos - 3'd1) : tail_pos;
        sel_kind   = 1'b0;
        sel_slot   = SLOT_W'(tail_pos);
        sel_bcount = '0;
        sel_vtx    = gen_cur_reg;
        if (gen_idx_reg == 3'd0)
        begin
            sel_slot = gen_slot_reg;
        end
        else if (gen_idx_reg == 3'd1)
        begin
            sel_kind   = 1'b1;
            sel_slot   = '0;
            sel_bcount = gen_bcount_reg;
            sel_vtx    = '0;
        end
        else if (gen_fan_reg && (tail_pos == 3'd0))
        begin
            sel_vtx = gen_first_reg;
        end
        else if ((gen_over_reg == 2'd2) && (tail_idx == 3'd0))
        begin
            sel_vtx = gen_pen_reg;
        end
    end

    // Load the result register, drop it once taken
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_kind_next   = res_kind_reg;
        res_slot_next   = res_slot_reg;
        res_vtx_next    = res_vtx_reg;
        res_bcount_next = res_bcount_reg;
        res_last_next   = res_last_reg;
        if (emit)
        begin
            res_valid_next  = 1'b1;
            res_kind_next   = sel_kind;
            res_slot_next   = sel_slot;
            res_vtx_next    = sel_vtx;
            res_bcount_next = sel_bcount;
            res_last_next   = gen_last;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_reg      <= '0;
            fill_reg      <= '0;
            gen_busy_reg  <= 1'b0;
            gen_idx_reg   <= '0;
            gen_cnt_reg   <= 3'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            prim_reg      <= prim_next;
            fill_reg      <= fill_next;
            gen_busy_reg  <= gen_busy_next;
            gen_idx_reg   <= gen_idx_next;
            gen_cnt_reg   <= gen_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        pen_reg        <= pen_next;
        gen_slot_reg   <= gen_slot_next;
        gen_bcount_reg <= gen_bcount_next;
        gen_over_reg   <= gen_over_next;
        gen_fan_reg    <= gen_fan_next;
        gen_cur_reg    <= gen_cur_next;
        gen_pen_reg    <= gen_pen_next;
        gen_first_reg  <= gen_first_next;
        res_kind_reg   <= res_kind_next;
        res_slot_reg   <= res_slot_next;
        res_vtx_reg    <= res_vtx_next;
        res_bcount_reg <= res_bcount_next;
        res_last_reg   <= res_last_next;
    end

    // Drive the result ports
    assign res_valid   = res_valid_reg;
    assign kind        = res_kind_reg;
    assign slot        = res_slot_reg;
    assign pos_xy      = res_vtx_reg.pos_xy;
    assign pos_zw      = res_vtx_reg.pos_z;
    assign tex_uv      = res_vtx_reg.tex;
    assign color_word  = res_vtx_reg.color;
    assign normal_xy   = res_vtx_reg.normal_xy;
    assign normal_zz   = res_vtx_reg.normal_z;
    assign batch_count = res_bcount_reg;
    assign last_result = res_last_reg;

    // Fill level stays below the batch depth between vertices
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CW'(BATCH_DEPTH))
        else $error("fill level reached batch depth");

    // A sequence carries between one and five results
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        gen_busy_reg |-> ((gen_cnt_reg != 3'd0) && (gen_cnt_reg <= 3'd5)
                          && (gen_idx_reg < gen_cnt_reg)))
        else $error("result sequence out of range");

    // A flush reports a full batch or a completed quad
    a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_kind_reg) |->
            ((res_bcount_reg == SLOT_W'(BATCH_DEPTH))
             || (res_bcount_reg == SLOT_W'(QUAD_SIZE))))
        else $error("flush with wrong batch count");

    // An accepted vertex is loaded into the sequencer, starting at its write result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (gen_busy_reg && (gen_idx_reg == 3'd0)))
        else $error("accepted vertex not loaded into sequencer");

    // The result that ends a sequence is presented with its last flag set
    a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && gen_last) |=> (res_valid_reg && res_last_reg))
        else $error("last result not presented");

endmodule

`default_nettype wire

// ----- tb/vertex_batch_checker.sv -----
`timescale 1ns / 1ps

module vertex_batch_checker
    import vba_pkg::*;
#(
    parameter int BATCH_DEPTH = 12
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,

    input  logic               vtx_valid,
    input  logic               vtx_ready,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic [31:0]        pos_z,
    input  logic [31:0]        tex_u,
    input  logic [31:0]        tex_v,
    input  logic [31:0]        rgba,
    input  logic [31:0]        norm_x,
    input  logic [31:0]        norm_y,
    input  logic [31:0]        norm_z,

    input  logic               res_valid,
    input  logic               res_ready,
    input  logic               kind,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [63:0]        pos_xy,
    input  logic [31:0]        pos_zw,
    input  logic [63:0]        tex_uv,
    input  logic [31:0]        color_word,
    input  logic [63:0]        normal_xy,
    input  logic [31:0]        normal_zz,
    input  logic [SLOT_W-1:0]  batch_count,
    input  logic               last_result,

    output int                 mismatch_count,
    output int                 outstanding,
    output int                 checked_count,
    output int                 flush_count
);

    // Result kinds
    localparam logic RES_WRITE = 1'b0;
    localparam logic RES_FLUSH = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [63:0]        pos_xy;
        logic [31:0]        pos_zw;
        logic [63:0]        tex_uv;
        logic [31:0]        color_word;
        logic [63:0]        normal_xy;
        logic [31:0]        normal_zz;
        logic [SLOT_W-1:0]  batch_count;
        logic               last_result;
    } batch_result_t;

    // Mirror of the batch store and the primitive register
    logic [3:0]      prim_mode;
    int              fill;
    vtx_t            batch_store [BATCH_DEPTH];
    int              carry_table [16];
    batch_result_t   due_results [$];

    vtx_t            in_vtx;
    batch_result_t   seen;
    batch_result_t   want;

    // Trailing vertices carried into the next batch, per primitive code
    initial
    begin
        for (int k = 0; k < 16; k++)
            carry_table[k] = 0;
        carry_table[PRIM_LINE_LOOP]  = 1;
        carry_table[PRIM_LINE_STRIP] = 1;
        carry_table[PRIM_POLYGON]    = 1;
        carry_table[PRIM_TRISTRIP]   = 2;
        carry_table[PRIM_FAN]        = 2;
        carry_table[PRIM_QUADSTRIP]  = 2;
    end

    function automatic batch_result_t slot_write(input int s, input vtx_t v);
        batch_result_t r;
        r = '0;
        r.kind       = RES_WRITE;
        r.slot       = s[SLOT_W-1:0];
        r.pos_xy     = v.pos_xy;
        r.pos_zw     = v.pos_z;
        r.tex_uv     = v.tex;
        r.color_word = v.color;
        r.normal_xy  = v.normal_xy;
        r.normal_zz  = v.normal_z;
        return r;
    endfunction

    // Place one vertex and queue the writes, flush and carried copies it causes
    task automatic batch_vertex(input vtx_t v);
        batch_result_t produced [5];
        vtx_t          tail [2];
        int            n;
        int            target;
        int            carry;
        int            count;
        int            i;
        n = 0;
        target = (fill >= BATCH_DEPTH) ? 0 : fill;
        batch_store[target] = v;
        produced[n] = slot_write(target, v);
        n++;
        fill = target + 1;

        if (fill == BATCH_DEPTH || (prim_mode == PRIM_QUADS && fill == QUAD_SIZE))
        begin
            carry = carry_table[prim_mode];
            count = fill;
            produced[n] = '0;
            produced[n].kind = RES_FLUSH;
            produced[n].batch_count = count[SLOT_W-1:0];
            n++;
            for (i = 0; i < carry; i++)
                tail[i] = batch_store[count - carry + i];

            // Fan and polygon restart from the first vertex of the batch
            target = 0;
            if (carry != 0 && (prim_mode == PRIM_FAN || prim_mode == PRIM_POLYGON))
            begin
                produced[n] = slot_write(0, batch_store[0]);
                n++;
                target = 1;
            end
            for (i = 0; i < carry; i++)
            begin
                batch_store[target] = tail[i];
                produced[n] = slot_write(target, tail[i]);
                n++;
                target++;
            end
            fill = target;
        end

        produced[n - 1].last_result = 1'b1;
        for (i = 0; i < n; i++)
            due_results.push_back(produced[i]);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Track config, predict on each vertex request, compare each result request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // power up in points mode with an empty batch
            prim_mode = '0;
            fill = 0;
            due_results.delete();
            mismatch_count = 0;
            checked_count = 0;
            flush_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
                prim_mode = cfg_wr_data;

            if (vtx_valid && vtx_ready)
            begin
                in_vtx.pos_xy    = {pos_y, pos_x};
                in_vtx.pos_z     = pos_z;
                in_vtx.tex       = {tex_v, tex_u};
                in_vtx.color     = rgba;
                in_vtx.normal_xy = {norm_y, norm_x};
                in_vtx.normal_z  = norm_z;
                batch_vertex(in_vtx);
            end

            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d slot %0d count %0d",
                           kind, slot, batch_count);
                    mismatch_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(kind));
                    check_field("slot", 64'(want.slot), 64'(slot));
                    check_field("pos_xy", want.pos_xy, pos_xy);
                    check_field("pos_zw", 64'(want.pos_zw), 64'(pos_zw));
                    check_field("tex_uv", want.tex_uv, tex_uv);
                    check_field("color_word", 64'(want.color_word), 64'(color_word));
                    check_field("normal_xy", want.normal_xy, normal_xy);
                    check_field("normal_zz", 64'(want.normal_zz), 64'(normal_zz));
                    check_field("batch_count", 64'(want.batch_count), 64'(batch_count));
                    check_field("last_result", 64'(want.last_result), 64'(last_result));
                    checked_count++;
                    if (want.kind == RES_FLUSH)
                        flush_count++;
                end
            end
        end
        outstanding = due_results.size();
    end

endmodule

// ----- tb/tb_vertex_batch_assembler.sv -----
`timescale 1ns / 1ps

module tb_vertex_batch_assembler;
    import vba_pkg::*;

    localparam int BATCH_DEPTH = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    // Primitive codes with no special handling in the block
    localparam logic [3:0] PRIM_POINTS     = 4'd0;
    localparam logic [3:0] PRIM_LINES      = 4'd1;
    localparam logic [3:0] PRIM_TRIANGLES  = 4'd4;
    localparam logic [3:0] PRIM_SPRITES    = 4'd10;
    localparam logic [3:0] PRIM_UNKNOWN_LO = 4'd11;
    localparam logic [3:0] PRIM_UNKNOWN_HI = 4'd15;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [3:0]         cfg_wr_data = '0;
    logic               vtx_valid = 1'b0;
    logic               vtx_ready;
    logic [31:0]        pos_x = '0;
    logic [31:0]        pos_y = '0;
    logic [31:0]        pos_z = '0;
    logic [31:0]        tex_u = '0;
    logic [31:0]        tex_v = '0;
    logic [31:0]        rgba = '0;
    logic [31:0]        norm_x = '0;
    logic [31:0]        norm_y = '0;
    logic [31:0]        norm_z = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [63:0]        pos_xy;
    logic [31:0]        pos_zw;
    logic [63:0]        tex_uv;
    logic [31:0]        color_word;
    logic [63:0]        normal_xy;
    logic [31:0]        normal_zz;
    logic [SLOT_W-1:0]  batch_count;
    logic               last_result;

    int mismatch_count;
    int outstanding;
    int checked_count;
    int flush_count;

    int send_gap_pct = 0;
    int ready_gap_pct = 0;
    int cycle_count = 0;
    int vertices_sent = 0;
    int settings_written = 0;

    always #1 clk = ~clk;

    vertex_batch_assembler #(.BATCH_DEPTH(BATCH_DEPTH)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .vtx_valid   (vtx_valid),
        .vtx_ready   (vtx_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .rgba        (rgba),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .slot        (slot),
        .pos_xy      (pos_xy),
        .pos_zw      (pos_zw),
        .tex_uv      (tex_uv),
        .color_word  (color_word),
        .normal_xy   (normal_xy),
        .normal_zz   (normal_zz),
        .batch_count (batch_count),
        .last_result (last_result)
    );

    vertex_batch_checker #(.BATCH_DEPTH(BATCH_DEPTH)) batch_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .vtx_valid      (vtx_valid),
        .vtx_ready      (vtx_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .rgba           (rgba),
        .norm_x         (norm_x),
        .norm_y         (norm_y),
        .norm_z         (norm_z),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .kind           (kind),
        .slot           (slot),
        .pos_xy         (pos_xy),
        .pos_zw         (pos_zw),
        .tex_uv         (tex_uv),
        .color_word     (color_word),
        .normal_xy      (normal_xy),
        .normal_zz      (normal_zz),
        .batch_count    (batch_count),
        .last_result    (last_result),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .checked_count  (checked_count),
        .flush_count    (flush_count)
    );

    // Stall the result side at random
    always @(negedge clk)
        res_ready = ($urandom_range(0, 99) >= ready_gap_pct);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] random_word();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [8:0][31:0] random_vertex();
        logic [8:0][31:0] w;
        int i;
        for (i = 0; i < 9; i++)
            w[i] = random_word();
        return w;
    endfunction

    // Present one vertex request and hold it until accepted; call at a falling edge
    task automatic drive_vertex(input logic [8:0][31:0] w);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            vtx_valid = 1'b0;
            @(negedge clk);
        end
        pos_x  = w[0];
        pos_y  = w[1];
        pos_z  = w[2];
        tex_u  = w[3];
        tex_v  = w[4];
        rgba   = w[5];
        norm_x = w[6];
        norm_y = w[7];
        norm_z = w[8];
        vtx_valid = 1'b1;
        do
            @(posedge clk);
        while (!vtx_ready);
        @(negedge clk);
        vertices_sent++;
    endtask

    // Drain all outstanding results, then write the primitive register
    task automatic set_primitive(input logic [3:0] code);
        vtx_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = code;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        settings_written++;
    endtask

    task automatic run_segment(input logic [3:0] code, input int count);
        set_primitive(code);
        repeat (count)
            drive_vertex(random_vertex());
    endtask

    initial
    begin
        logic [3:0] plan [15];
        int p;
        int s;

        plan = '{PRIM_LINE_LOOP, PRIM_TRISTRIP, PRIM_POLYGON, PRIM_QUADSTRIP,
                 PRIM_LINE_STRIP, PRIM_LINES, PRIM_TRIANGLES, PRIM_SPRITES,
                 PRIM_UNKNOWN_LO, PRIM_FAN, PRIM_QUADS, PRIM_POINTS,
                 PRIM_UNKNOWN_HI, PRIM_POLYGON, PRIM_FAN};

        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Field extremes in the reset mode (points)
        drive_vertex('0);
        drive_vertex('1);

        // Switch to quads mid-batch so the fourth vertex completes a quad
        set_primitive(PRIM_QUADS);
        drive_vertex({9{32'hAAAA_AAAA}});
        drive_vertex({9{32'h5555_5555}});

        // Fill a whole fan batch: flush plus first vertex and two carried copies
        set_primitive(PRIM_FAN);
        drive_vertex('1);
        repeat (10)
            drive_vertex(random_vertex());
        drive_vertex('0);

        // Unknown codes behave like points
        set_primitive(PRIM_UNKNOWN_HI);
        drive_vertex({9{32'h8000_0001}});
        drive_vertex({9{32'h7FFF_FFFE}});
        drive_vertex(random_vertex());

        // Random segments under three idling profiles
        for (p = 0; p < 3; p++)
        begin
            send_gap_pct  = (p == 0) ? 15 : (p == 1) ? 85 : 0;
            ready_gap_pct = (p == 0) ? 85 : (p == 1) ? 15 : 0;
            for (s = 0; s < 5; s++)
                run_segment(plan[p * 5 + s], $urandom_range(8, 18));
        end

        // Drain and let any stray result show up
        vtx_valid = 1'b0;
        ready_gap_pct = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("Sent %0d vertices over %0d primitive settings, unknown codes included;",
                 vertices_sent, settings_written);
        $display("checked %0d results with %0d batch flushes, %0d mismatches.",
                 checked_count, flush_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
